/* rtl/core/krt_pkg.sv */
package krt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PICK_COUNT  = 3;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PK_W  = $clog2(PICK_COUNT + 1);
    localparam int PS_W  = (PICK_COUNT > 1) ? $clog2(PICK_COUNT) : 1;
    localparam int KEY_W = 16;
    localparam int VAL_W = 32;

    localparam logic [1:0] KIND_SELECTED = 2'd0;
    localparam logic [1:0] KIND_NONE     = 2'd1;
    localparam logic [1:0] KIND_DROPPED  = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic                    rep;
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
    } t_entry;

    typedef logic [PICK_COUNT-1:0][KEY_W-1:0] t_klist;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

/* rtl/core/krt_table.sv */
module krt_table (
    input  logic             i_clk,
    input  krt_pkg::t_mem_req i_req,
    output krt_pkg::t_entry  o_rdata
);
    import krt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* rtl/core/krt_pick_list.sv */
module krt_pick_list (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_ins,
    input  logic [krt_pkg::KEY_W-1:0]  i_key,
    output krt_pkg::t_klist            o_list,
    output logic [krt_pkg::PK_W-1:0]   o_count
);
    import krt_pkg::*;

    t_klist           r_list, n_list;
    logic [PK_W-1:0]  r_count;
    logic [PICK_COUNT-1:0] w_gt;

    // The list stays sorted: the new key goes in ahead of every larger key.
    always_comb begin
        for (int k = 0; k < PICK_COUNT; k++) begin
            w_gt[k] = (PK_W'(k) < r_count) && (r_list[k] > i_key);
        end
        for (int k = 0; k < PICK_COUNT; k++) begin
            if (PK_W'(k) > r_count || (PK_W'(k) < r_count && !w_gt[k])) begin
                n_list[k] = r_list[k];
            end else if (k == 0 || !w_gt[(k == 0) ? 0 : k - 1]) begin
                n_list[k] = i_key;
            end else begin
                n_list[k] = r_list[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
        end else if (i_ins) begin
            r_count <= r_count + PK_W'(1);
        end
        if (i_ins) begin
            r_list <= n_list;
        end
    end

    assign o_list  = r_list;
    assign o_count = r_count;

endmodule

/* rtl/core/keyed_range_tracker_select.sv */
// Keyed range table; r_fill counts the live entries. A sample transaction
// scans the live entries in the table memory with one read issued per cycle; a hit
// ends the scan early and writes the entry back. A report runs up to three passes,
// each a full scan and a compaction sweep that moves every later entry down one
// slot. When fewer than three entries qualify, one more scan finds nothing. Then one
// result is loaded per cycle while the output register is free. The table memory
// has a single read port. Input stall stays high from acceptance until a sample
// is written back or appended, or until the last result is loaded into the output
// register.
module keyed_range_tracker_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_opcode,
    input  logic [krt_pkg::KEY_W-1:0]         i_key,
    input  logic signed [krt_pkg::VAL_W-1:0]  i_sample_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [krt_pkg::KEY_W-1:0]         o_result_key,
    output logic [1:0]                        o_kind,
    output logic                              o_last
);
    import krt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_HIT   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill, r_ra, n_ra;
    logic r_pv, n_pv;
    logic [IDX_W-1:0] r_pi, n_pi, r_bidx, n_bidx;
    logic r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key, r_bkey, n_bkey;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic r_found, n_found;
    logic signed [VAL_W:0] r_best, n_best;
    t_entry r_ent, n_ent;
    logic [1:0] r_ekind, n_ekind;
    logic [PS_W-1:0] r_oi, n_oi;
    logic r_ov, n_ov;
    logic [KEY_W-1:0] r_okey, n_okey;
    logic [1:0] r_okind, n_okind;
    logic r_olast, n_olast;

    t_mem_req w_req;
    t_entry   w_rd;
    t_klist   w_list;
    logic [PK_W-1:0] w_cnt;
    logic w_clear, w_ins;
    logic w_accept, w_issue, w_slot;
    logic signed [VAL_W:0] w_spread;

    krt_table u_table (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rd)
    );

    krt_pick_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_ins   (w_ins),
        .i_key   (r_bkey),
        .o_list  (w_list),
        .o_count (w_cnt)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_issue  = (r_ra < r_fill);
    assign w_slot   = !r_ov || !i_stall;
    assign w_spread = {w_rd.high[VAL_W-1], w_rd.high} - {w_rd.low[VAL_W-1], w_rd.low};

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_ra    = r_ra;
        n_pv    = 1'b0;
        n_pi    = r_ra[IDX_W-1:0];
        n_bidx  = r_bidx;
        n_op    = r_op;
        n_key   = r_key;
        n_bkey  = r_bkey;
        n_val   = r_val;
        n_found = r_found;
        n_best  = r_best;
        n_ent   = r_ent;
        n_ekind = r_ekind;
        n_oi    = r_oi;
        n_ov    = r_ov && i_stall;
        n_okey  = r_okey;
        n_okind = r_okind;
        n_olast = r_olast;
        w_clear = 1'b0;
        w_ins   = 1'b0;
        w_req.we    = 1'b0;
        w_req.waddr = r_fill[IDX_W-1:0];
        w_req.wdata = r_ent;
        w_req.raddr = r_ra[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_opcode;
                    n_key   = i_key;
                    n_val   = i_sample_value;
                    n_ra    = '0;
                    n_found = 1'b0;
                    w_clear = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pv = w_issue;
                if (w_issue) begin
                    n_ra = r_ra + CNT_W'(1);
                end
                if (r_pv && r_op == OP_SAMPLE && w_rd.key == r_key) begin
                    n_bidx  = r_pi;
                    n_ent   = w_rd;
                    n_pv    = 1'b0;
                    n_state = S_HIT;
                end else if (r_pv) begin
                    if (r_op == OP_REPORT && w_rd.rep && (!r_found || w_spread < r_best)) begin
                        n_found = 1'b1;
                        n_bidx  = r_pi;
                        n_best  = w_spread;
                        n_bkey  = w_rd.key;
                    end
                end else if (!w_issue) begin
                    // Scan finished without an early exit.
                    if (r_op == OP_SAMPLE) begin
                        if (r_fill >= CNT_W'(TABLE_DEPTH)) begin
                            n_ekind = KIND_DROPPED;
                            n_state = S_EMIT;
                        end else begin
                            w_req.we    = 1'b1;
                            w_req.wdata = '{key: r_key, rep: 1'b0, low: r_val, high: r_val};
                            n_fill  = r_fill + CNT_W'(1);
                            n_state = S_IDLE;
                        end
                    end else if (r_found) begin
                        w_ins   = 1'b1;
                        n_ra    = CNT_W'(r_bidx) + CNT_W'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_ekind = (w_cnt == '0) ? KIND_NONE : KIND_SELECTED;
                        n_oi    = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_HIT: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_bidx;
                w_req.wdata = '{key: r_ent.key, rep: 1'b1,
                                low: (r_val < r_ent.low) ? r_val : r_ent.low,
                                high: (r_val > r_ent.high) ? r_val : r_ent.high};
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                n_pv = w_issue;
                if (w_issue) begin
                    n_ra = r_ra + CNT_W'(1);
                end
                if (r_pv) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_pi - IDX_W'(1);
                    w_req.wdata = w_rd;
                end else if (!w_issue) begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_ra    = '0;
                    n_found = 1'b0;
                    if (w_cnt == PK_W'(PICK_COUNT)) begin
                        n_ekind = KIND_SELECTED;
                        n_oi    = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_ov    = 1'b1;
                    n_okind = r_ekind;
                    if (r_ekind == KIND_SELECTED) begin
                        n_okey  = w_list[r_oi];
                        n_olast = (PK_W'(r_oi) == w_cnt - PK_W'(1));
                        n_oi    = r_oi + PS_W'(1);
                    end else begin
                        n_okey  = (r_ekind == KIND_DROPPED) ? r_key : '0;
                        n_olast = 1'b1;
                    end
                    if (n_olast) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_found <= n_found;
        end
        r_ra    <= n_ra;
        r_pi    <= n_pi;
        r_bidx  <= n_bidx;
        r_op    <= n_op;
        r_key   <= n_key;
        r_bkey  <= n_bkey;
        r_val   <= n_val;
        r_best  <= n_best;
        r_ent   <= n_ent;
        r_ekind <= n_ekind;
        r_oi    <= n_oi;
        r_okey  <= n_okey;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign o_valid      = r_ov;
    assign o_result_key = r_okey;
    assign o_kind       = r_okind;
    assign o_last       = r_olast;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_pick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= PK_W'(PICK_COUNT))
        else $error("too many picked keys");

    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_req.we) |-> (CNT_W'(w_req.waddr) < r_fill))
        else $error("compaction write outside live entries");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted transaction did not start a scan");

endmodule

/* dv/keyed_range_tracker_select_tb.sv */
module keyed_range_tracker_select_tb;
    import krt_pkg::*;

    typedef struct packed {
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] val;
    } t_txn;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [1:0]       kind;
        logic             last;
    } t_res;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_opcode = 1'b0;
    logic [KEY_W-1:0]        i_key = '0;
    logic signed [VAL_W-1:0] i_sample_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [KEY_W-1:0]        o_result_key;
    logic [1:0]              o_kind;
    logic                    o_last;

    keyed_range_tracker_select dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the range table, kept compact in arrival order.
    logic [KEY_W-1:0]        tbl_key[$];
    logic                    tbl_rep[$];
    logic signed [VAL_W-1:0] tbl_low[$];
    logic signed [VAL_W-1:0] tbl_high[$];

    t_txn pending_txns[$];
    t_res expected_results[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_send = 0;
    int   n_errors = 0;
    int   n_sent = 0;
    int   n_results = 0;
    int   n_drops = 0;
    int   n_nones = 0;
    longint cycle = 0;

    task automatic add_txn(input t_txn t);
        pending_txns = {pending_txns, t};
    endtask

    task automatic add_expect(input t_res r);
        expected_results = {expected_results, r};
    endtask

    task automatic predict_table(input t_txn t);
        logic [KEY_W-1:0] picked[$];
        logic signed [VAL_W:0] spread, best_spread;
        int best;
        int i;
        if (t.op == OP_SAMPLE) begin
            for (i = 0; i < tbl_key.size(); i++) begin
                if (tbl_key[i] == t.key) begin
                    tbl_rep[i] = 1'b1;
                    if (t.val < tbl_low[i]) tbl_low[i] = t.val;
                    if (t.val > tbl_high[i]) tbl_high[i] = t.val;
                    return;
                end
            end
            if (tbl_key.size() >= TABLE_DEPTH) begin
                add_expect('{t.key, KIND_DROPPED, 1'b1});
            end else begin
                tbl_key  = {tbl_key, t.key};
                tbl_rep  = {tbl_rep, 1'b0};
                tbl_low  = {tbl_low, t.val};
                tbl_high = {tbl_high, t.val};
            end
        end else begin
            for (int p = 0; p < PICK_COUNT; p++) begin
                best = -1;
                for (i = 0; i < tbl_key.size(); i++) begin
                    if (tbl_rep[i]) begin
                        spread = {tbl_high[i][VAL_W-1], tbl_high[i]}
                               - {tbl_low[i][VAL_W-1], tbl_low[i]};
                        if (best < 0 || spread < best_spread) begin
                            best = i;
                            best_spread = spread;
                        end
                    end
                end
                if (best < 0) break;
                picked = {picked, tbl_key[best]};
                tbl_key.delete(best);
                tbl_rep.delete(best);
                tbl_low.delete(best);
                tbl_high.delete(best);
            end
            if (picked.size() == 0) begin
                add_expect('{'0, KIND_NONE, 1'b1});
            end else begin
                picked.sort();
                foreach (picked[k])
                    add_expect('{picked[k], KIND_SELECTED, k == picked.size() - 1});
            end
        end
    endtask

    // Driver: a transaction leaves the queue when it is presented, and is predicted when accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_table('{i_opcode, i_key, i_sample_value});
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_txns.size() > 0 && !hold_send
                        && $urandom_range(99) >= send_idle_pct) begin
                    i_valid        <= 1'b1;
                    i_opcode       <= pending_txns[0].op;
                    i_key          <= pending_txns[0].key;
                    i_sample_value <= pending_txns[0].val;
                    void'(pending_txns.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        cycle++;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_res want;
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result key=%h kind=%0d last=%0d",
                                 o_result_key, o_kind, o_last);
                end else begin
                    want = expected_results.pop_front();
                    if (want.kind == KIND_DROPPED) n_drops++;
                    if (want.kind == KIND_NONE) n_nones++;
                    if (want != t_res'{o_result_key, o_kind, o_last}) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected key=%h kind=%0d last=%0d, got key=%h kind=%0d last=%0d",
                                     want.key, want.kind, want.last,
                                     o_result_key, o_kind, o_last);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_txn sample_txn(input logic [KEY_W-1:0] k, input logic [31:0] v);
        return '{OP_SAMPLE, k, v};
    endfunction

    function automatic t_txn report_txn();
        return '{OP_REPORT, KEY_W'($urandom), VAL_W'($urandom)};
    endfunction

    task automatic drain();
        while (pending_txns.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic add_random_phase(input int n);
        logic [KEY_W-1:0] base;
        int span;
        base = KEY_W'($urandom);
        for (int i = 0; i < n; i++) begin
            span = ($urandom_range(9) == 0) ? 90 : 20;
            if ($urandom_range(5) == 0)
                add_txn(report_txn());
            else if ($urandom_range(3) == 0)
                add_txn(sample_txn(KEY_W'($urandom), $urandom));
            else
                add_txn(sample_txn(base + KEY_W'($urandom_range(span - 1)),
                    ($urandom_range(1) ? $urandom : 32'($signed($urandom_range(600)) - 300))));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty report, extremes, equal spreads, full table, drops.
        add_txn(report_txn());
        add_txn(sample_txn(16'hFFFF, 32'h8000_0000));
        add_txn(sample_txn(16'hFFFF, 32'h7FFF_FFFF));
        add_txn(sample_txn(16'h0000, 32'h0000_0005));
        add_txn(sample_txn(16'h0000, 32'h0000_0007));
        add_txn(sample_txn(16'h00AA, 32'hFFFF_FFFF));
        add_txn(sample_txn(16'h00AA, 32'h0000_0001));
        add_txn(sample_txn(16'h5555, 32'h0001_0000));
        add_txn(sample_txn(16'h5555, 32'h0001_0000));
        add_txn(report_txn());
        add_txn(report_txn());
        add_txn(report_txn());
        for (int k = 0; k < TABLE_DEPTH; k++)
            add_txn(sample_txn(KEY_W'(16'h1000 + k), 32'(k)));
        add_txn(sample_txn(16'hAAAA, 32'h1234_5678));
        add_txn(sample_txn(16'h1003, 32'hFFFF_0000));
        add_txn(sample_txn(16'h1007, 32'h0000_0007));
        add_txn(report_txn());
        drain();

        // Queue a phase while sending is held back, then release it all at once.
        hold_send = 1;
        add_random_phase(20);
        repeat (200) @(posedge i_clk);
        hold_send = 0;
        drain();

        add_random_phase(68);
        drain();
        send_idle_pct = 45;
        add_random_phase(68);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 45;
        add_random_phase(68);
        drain();
        send_idle_pct = 21;
        recv_stall_pct = 21;
        add_random_phase(68);
        drain();

        $display("Sent %0d transactions, checked %0d results (%0d drops, %0d empty reports).",
                 n_sent, n_results, n_drops, n_nones);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("keyed_range_tracker_select_tb OK");
        else
            $display("keyed_range_tracker_select_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle > 1000000) begin
            $display("timeout");
            $display("keyed_range_tracker_select_tb NOT OK");
            $finish;
        end
    end
endmodule

/* filelist.f */
rtl/core/krt_pkg.sv
rtl/core/krt_table.sv
rtl/core/krt_pick_list.sv
rtl/core/keyed_range_tracker_select.sv
dv/keyed_range_tracker_select_tb.sv
